// ===== sv/dedup_fifo_queue_assert.svh =====
// Assertion macros shared by the queue's checking code.
`ifndef DEDUP_FIFO_QUEUE_ASSERT_SVH
`define DEDUP_FIFO_QUEUE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define DFQ_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define DFQ_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== sv/dfq_pkg.sv =====
package dfq_pkg;

	localparam int DEPTH   = 16;
	localparam int ID_BITS = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_CLR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic               shift;
		logic               clear;
		logic               load;
		logic [ID_BITS-1:0] id;
	} cell_ctl_t;

endpackage

// ===== sv/dfq_cell.sv =====
module dfq_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfq_pkg::cell_ctl_t          ctl,
	input  logic                        prev_valid,
	input  logic                        next_valid,
	input  logic [dfq_pkg::ID_BITS-1:0] next_id,
	input  logic                        match_in,
	output logic                        match_out,
	output logic                        valid,
	output logic [dfq_pkg::ID_BITS-1:0] id
);

	logic                        valid_q;
	logic [dfq_pkg::ID_BITS-1:0] id_q;

	assign valid     = valid_q;
	assign id        = id_q;
	assign match_out = match_in | (valid_q && (id_q == ctl.id));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.load && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	// The first free cell behind the occupied run takes the new word.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			id_q <= next_id;
		end else if (ctl.load && !valid_q && prev_valid) begin
			id_q <= ctl.id;
		end
	end

endmodule

// ===== sv/dedup_fifo_queue.sv =====
// Duplicate-rejecting FIFO of identifiers. A request is taken on any cycle
// with start high (busy is always low), and its result appears on the
// following cycle for exactly one cycle, marked by done; the receiver
// cannot stall, so the result must be captured while done is high. One
// request per cycle is sustained. The queue is a row of DEPTH cells holding
// words oldest first; a dequeue moves every word one cell toward the head,
// and the duplicate check ripples a match flag through all cells, which
// sets the clock period.
module dedup_fifo_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] new_id,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [4:0]  occupancy,
	output logic        is_empty
);

	localparam int DEPTH   = dfq_pkg::DEPTH;
	localparam int ID_BITS = dfq_pkg::ID_BITS;
	localparam int CNT_W   = dfq_pkg::CNT_W;

	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       cnt_nxt;
	logic [DEPTH-1:0]       valid_vec;
	logic [ID_BITS-1:0]     id_c [DEPTH];
	logic [DEPTH:0]         match_c;
	dfq_pkg::cell_ctl_t     ctl;
	dfq_pkg::status_t       status_nxt;
	logic [ID_BITS-1:0]     removed;
	logic                   dup;
	logic                   full;
	logic                   empty;

	assign busy  = 1'b0;
	assign dup   = match_c[DEPTH];
	assign full  = valid_vec[DEPTH-1];
	assign empty = !valid_vec[0];

	assign match_c[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  prev_v;
		logic                  next_v;
		logic [ID_BITS-1:0]    next_d;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_inner
			assign next_v = valid_vec[i+1];
			assign next_d = id_c[i+1];
		end

		dfq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_valid(prev_v),
			.next_valid(next_v),
			.next_id   (next_d),
			.match_in  (match_c[i]),
			.match_out (match_c[i+1]),
			.valid     (valid_vec[i]),
			.id        (id_c[i])
		);
	end

	always_comb begin
		ctl.shift  = 1'b0;
		ctl.clear  = 1'b0;
		ctl.load   = 1'b0;
		ctl.id     = new_id[ID_BITS-1:0];
		status_nxt = dfq_pkg::ST_DONE;
		removed    = '0;
		cnt_nxt    = cnt_q;
		case (dfq_pkg::mode_t'(mode))
			dfq_pkg::MODE_ENQ: begin
				if (dup) begin
					status_nxt = dfq_pkg::ST_DUP;
				end else if (full) begin
					status_nxt = dfq_pkg::ST_FULL;
				end else begin
					ctl.load = start;
					cnt_nxt  = cnt_q + CNT_W'(1);
				end
			end
			dfq_pkg::MODE_DEQ: begin
				if (empty) begin
					status_nxt = dfq_pkg::ST_EMPTY;
				end else begin
					ctl.shift = start;
					removed   = id_c[0];
					cnt_nxt   = cnt_q - CNT_W'(1);
				end
			end
			dfq_pkg::MODE_CLR: begin
				if (empty) begin
					status_nxt = dfq_pkg::ST_EMPTY;
				end else begin
					ctl.clear = start;
					cnt_nxt   = '0;
				end
			end
			default: begin
				status_nxt = dfq_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= start;
			if (start) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			status    <= status_nxt;
			out_id    <= 16'(removed);
			occupancy <= 5'(cnt_nxt);
			is_empty  <= (cnt_nxt == '0);
		end
	end

`include "dedup_fifo_queue_assert.svh"

	`DFQ_ASSERT_SAME(a_count_matches_cells, 1'b1, $countones(valid_vec) == 32'(cnt_q), "count differs from occupied cells")
	`DFQ_ASSERT_SAME(a_empty_flag, done, is_empty == (occupancy == 5'd0), "empty flag disagrees with occupancy")
	`DFQ_ASSERT_NEXT(a_word_reported, start, done && (5'(cnt_q) == occupancy), "result word missing or stale")

endmodule

// ===== tb/tb_dedup_fifo_queue.sv =====
`timescale 1ns / 100ps

module tb_dedup_fifo_queue;
	import dfq_pkg::*;

	// The mode field has one code that the block leaves unused.
	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam int N_RANDOM = 1050;
	localparam int POOL_SIZE = 24;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] id;
		bit          hold_off;
	} queue_req_t;

	typedef struct {
		status_t     status;
		logic [15:0] out_id;
		logic [4:0]  occupancy;
		logic        is_empty;
	} queue_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = MODE_ENQ;
	logic [15:0] new_id = 16'h0000;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [15:0] out_id;
	logic [4:0]  occupancy;
	logic        is_empty;

	queue_req_t  req_fifo[$];
	queue_resp_t predicted_results[$];
	queue_req_t  next_req;
	queue_resp_t want;

	// Shadow copy of the queue contents.
	logic [15:0] shadow_slots[DEPTH];
	logic [3:0]  shadow_head = 4'd0;
	logic [4:0]  shadow_count = 5'd0;

	int n_accepted = 0;
	int n_results = 0;
	int n_errors = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int peak_occupancy = 0;

	dedup_fifo_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.new_id    (new_id),
		.done      (done),
		.status    (status),
		.out_id    (out_id),
		.occupancy (occupancy),
		.is_empty  (is_empty)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit shadow_holds(input logic [15:0] id);
		logic [3:0] pos;
		for (int k = 0; k < shadow_count; k++) begin
			pos = shadow_head + k[3:0];
			if (shadow_slots[pos] == id)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_response(input logic [1:0] op, input logic [15:0] id);
		queue_resp_t r;
		r.status = ST_DONE;
		r.out_id = 16'h0000;
		if (op == MODE_ENQ) begin
			if (shadow_holds(id)) begin
				r.status = ST_DUP;
			end else if (shadow_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_slots[shadow_head + shadow_count[3:0]] = id;
				shadow_count = shadow_count + 5'd1;
			end
		end else if (op == MODE_DEQ) begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.out_id = shadow_slots[shadow_head];
				shadow_head = shadow_head + 4'd1;
				shadow_count = shadow_count - 5'd1;
			end
		end else if (op == MODE_CLR) begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				shadow_count = 5'd0;
				shadow_head = 4'd0;
			end
		end
		r.occupancy = shadow_count;
		r.is_empty = (shadow_count == 0);
		predicted_results.push_back(r);
	endtask

	function automatic int gap_percent(input int n);
		case ((n / 120) % 3)
			0: return 0;
			1: return 74;
			default: return 34;
		endcase
	endfunction

	task automatic add_req(input logic [1:0] op, input logic [15:0] id, input bit hold_off);
		queue_req_t q;
		q.op = op;
		q.id = id;
		q.hold_off = hold_off;
		req_fifo.push_back(q);
	endtask

	// Request side. A word held back by hold_off goes out only once every
	// earlier word has produced its result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_response(mode, new_id);
				n_accepted++;
			end
			if (start && busy) begin
				// The word stays on the ports until it is taken.
			end else if (req_fifo.size() != 0
					&& (!req_fifo[0].hold_off || n_accepted == n_results)
					&& $urandom_range(99) >= gap_percent(n_accepted)) begin
				next_req = req_fifo.pop_front();
				start <= 1'b1;
				mode <= next_req.op;
				new_id <= next_req.id;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results <= n_results + 1;
			if (predicted_results.size() == 0) begin
				$error("result with none expected: status %0d out_id %04h", status, out_id);
				n_errors++;
			end else begin
				want = predicted_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					n_errors++;
				end
				if (out_id !== want.out_id) begin
					$error("out_id: expected %04h, got %04h", want.out_id, out_id);
					n_errors++;
				end
				if (occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
					n_errors++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
					n_errors++;
				end
				status_seen[int'(want.status)]++;
				if (int'(want.occupancy) > peak_occupancy)
					peak_occupancy = int'(want.occupancy);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("** dedup_fifo_queue: FAILED **");
		$finish;
	end

	initial begin
		logic [15:0] id_pool[POOL_SIZE];
		logic [15:0] id;
		logic [1:0]  op;
		int          burst;
		int          len;
		int          roll;

		// Requests on an empty queue, then the extreme identifiers.
		add_req(MODE_CLR, 16'h5a5a, 1'b0);
		add_req(MODE_DEQ, 16'hffff, 1'b0);
		add_req(MODE_RSVD, 16'h1234, 1'b0);
		add_req(MODE_ENQ, 16'h0000, 1'b0);
		add_req(MODE_ENQ, 16'hffff, 1'b0);
		add_req(MODE_ENQ, 16'h0000, 1'b0);
		add_req(MODE_DEQ, 16'h0000, 1'b0);
		add_req(MODE_DEQ, 16'h0000, 1'b0);
		// The last entry is gone; the queue must behave as after reset.
		add_req(MODE_ENQ, 16'h8001, 1'b0);
		for (int i = 1; i < DEPTH; i++)
			add_req(MODE_ENQ, 16'h0101 * i[15:0] ^ 16'h8000, 1'b0);
		// Full queue: a new word is refused, a duplicate is reported as such.
		add_req(MODE_ENQ, 16'h7777, 1'b0);
		add_req(MODE_ENQ, 16'h8001, 1'b0);
		add_req(MODE_RSVD, 16'h0000, 1'b0);
		add_req(MODE_CLR, 16'h0000, 1'b0);

		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = 16'($urandom);

		// Bursts of enqueues from a small pool of identifiers reach both a
		// full queue and many duplicates; drains and clears empty it again.
		while (req_fifo.size() < N_RANDOM) begin
			if ($urandom_range(9) == 0)
				id_pool[$urandom_range(POOL_SIZE - 1)] = 16'($urandom);
			burst = $urandom_range(9);
			len = $urandom_range(1, 20);
			for (int k = 0; k < len; k++) begin
				id = ($urandom_range(3) == 0) ? 16'($urandom) : id_pool[$urandom_range(POOL_SIZE - 1)];
				if (burst <= 3) begin
					op = MODE_ENQ;
				end else if (burst <= 5) begin
					op = MODE_DEQ;
				end else if (burst == 9 && k == 0) begin
					op = MODE_CLR;
				end else begin
					roll = $urandom_range(99);
					if (roll < 50)
						op = MODE_ENQ;
					else if (roll < 85)
						op = MODE_DEQ;
					else if (roll < 95)
						op = MODE_CLR;
					else
						op = MODE_RSVD;
				end
				add_req(op, id, req_fifo.size() == 28 || $urandom_range(59) == 0);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (req_fifo.size() != 0 || start || n_results < n_accepted);
		repeat (4) @(posedge clk);

		if (predicted_results.size() != 0) begin
			$error("%0d expected results never arrived", predicted_results.size());
			n_errors++;
		end

		$display("Checked %0d requests: %0d done, %0d duplicates, %0d on empty, %0d full.",
			n_accepted, status_seen[ST_DONE], status_seen[ST_DUP],
			status_seen[ST_EMPTY], status_seen[ST_FULL]);
		$display("Peak occupancy %0d of %0d, with request gaps of 0, 34 and 74 percent.",
			peak_occupancy, DEPTH);
		if (n_errors == 0) begin
			$display("** dedup_fifo_queue: PASSED **");
		end else begin
			$display("** dedup_fifo_queue: FAILED **");
		end
		$finish;
	end

endmodule
